### design/gcd_pkg.sv
// Package for the genome compatibility distance block.
// Holds the sizes, command codes and item types; no dependencies.
package gcd_pkg;

    localparam int MAX_GENES = 256;
    localparam int ADDR_W    = $clog2(MAX_GENES);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int INN_W     = 16;
    localparam int WT_W      = 24;
    localparam int SUM_W     = WT_W + 1 + CNT_W - 1;
    localparam int DIVD_W    = 16 + SUM_W - 8;
    localparam int DIVS_W    = CNT_W;
    localparam int DCNT_W    = $clog2(DIVD_W + 1);

    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    localparam logic [1:0] REG_COEF_DISJOINT = 2'd0;
    localparam logic [1:0] REG_COEF_EXCESS   = 2'd1;
    localparam logic [1:0] REG_COEF_WEIGHT   = 2'd2;
    localparam logic [1:0] REG_SMALL_LIMIT   = 2'd3;

    localparam logic [1:0] TERM_DISJOINT = 2'd0;
    localparam logic [1:0] TERM_EXCESS   = 2'd1;
    localparam logic [1:0] TERM_WEIGHT   = 2'd2;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [INN_W-1:0]        innovation;
        logic signed [WT_W-1:0]  gene_weight;
    } in_t;

    typedef struct packed {
        logic [31:0] distance_value;
        logic [8:0]  matching_count;
        logic [9:0]  disjoint_count;
        logic [8:0]  excess_count;
        logic        overflow_flag;
    } out_t;

    typedef struct packed {
        logic       load_a;
        logic       load_b;
        logic       top_rd;
        logic       top_cmp;
        logic       walk_cmp;
        logic       mul;
        logic       div_start;
        logic       div_step;
        logic       div_store;
        logic [1:0] term_sel;
        logic       finish;
    } dp_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic div_done;
    } dp_status_t;

endpackage

### design/genome_compatibility_distance.sv
// Top level of the genome compatibility distance block.
// Joins gcd_ctrl and gcd_datapath; depends on gcd_pkg.
//
// A load item (genome A or genome B) is taken while busy stays low. A
// compute item raises busy for a time set by the number of merge steps
// (at most the sum of both gene counts), with one store read and one
// compare per step, and by a shared one-bit-a-step divider run once for
// each of the three terms. The result follows with done high for one
// cycle and must be taken then; both stores are empty again afterwards.
module genome_compatibility_distance (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  gcd_pkg::in_t  item,
    output logic          done,
    output gcd_pkg::out_t result,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data
);
    import gcd_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t status;

    gcd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (item.cmd),
        .status (status),
        .dp_cmd (dp_cmd),
        .busy   (busy)
    );

    gcd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .dp_cmd    (dp_cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .done      (done),
        .result    (result)
    );

endmodule

### design/gcd_ctrl.sv
// Controller state machine of the genome compatibility distance block.
// Depends on gcd_pkg for the command and status types.
module gcd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         cmd,
    input  gcd_pkg::dp_status_t status,
    output gcd_pkg::dp_cmd_t   dp_cmd,
    output logic               busy
);
    import gcd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_TOP_RD, S_TOP_CMP, S_WALK_RD, S_WALK_CMP, S_MUL,
        S_DIV_START, S_DIV_RUN, S_DIV_STORE, S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] term_reg, term_next;

    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        dp_cmd     = '0;
        dp_cmd.term_sel = term_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    dp_cmd.load_a = (cmd == CMD_LOAD_A);
                    dp_cmd.load_b = (cmd == CMD_LOAD_B);
                    if (cmd == CMD_COMPUTE)
                        state_next = S_TOP_RD;
                end
            end
            S_TOP_RD:
            begin
                dp_cmd.top_rd = 1'b1;
                state_next = S_TOP_CMP;
            end
            S_TOP_CMP:
            begin
                dp_cmd.top_cmp = 1'b1;
                state_next = S_WALK_RD;
            end
            S_WALK_RD:
                state_next = status.walk_done ? S_MUL : S_WALK_CMP;
            S_WALK_CMP:
            begin
                dp_cmd.walk_cmp = 1'b1;
                state_next = S_WALK_RD;
            end
            S_MUL:
            begin
                dp_cmd.mul = 1'b1;
                term_next  = TERM_DISJOINT;
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                dp_cmd.div_start = 1'b1;
                state_next = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                if (status.div_done)
                    state_next = S_DIV_STORE;
                else
                    dp_cmd.div_step = 1'b1;
            end
            S_DIV_STORE:
            begin
                dp_cmd.div_store = 1'b1;
                if (term_reg == TERM_WEIGHT)
                    state_next = S_DONE;
                else
                begin
                    term_next  = term_reg + 2'd1;
                    state_next = S_DIV_START;
                end
            end
            S_DONE:
            begin
                dp_cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            term_reg  <= TERM_DISJOINT;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

### design/gcd_datapath.sv
// Datapath of the genome compatibility distance block: gene stores, merge
// counters, multipliers and a shared restoring divider. Depends on gcd_pkg.
module gcd_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  gcd_pkg::in_t        item,
    input  gcd_pkg::dp_cmd_t    dp_cmd,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output gcd_pkg::dp_status_t status,
    output logic                done,
    output gcd_pkg::out_t       result
);
    import gcd_pkg::*;

    logic [INN_W-1:0] inn_a_mem [MAX_GENES];
    logic [WT_W-1:0]  wt_a_mem  [MAX_GENES];
    logic [INN_W-1:0] inn_b_mem [MAX_GENES];
    logic [WT_W-1:0]  wt_b_mem  [MAX_GENES];

    logic [15:0]       c1_reg, c2_reg, c3_reg;
    logic [9:0]        limit_reg;
    logic [CNT_W-1:0]  count_a_reg, count_b_reg;
    logic              ovf_reg;
    logic [INN_W-1:0]  rd_inn_a_reg, rd_inn_b_reg;
    logic [WT_W-1:0]   rd_wt_a_reg, rd_wt_b_reg;
    logic              swap_reg;
    logic [CNT_W-1:0]  p1_reg, p2_reg;
    logic [8:0]        match_reg;
    logic [9:0]        disj_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [8:0]        excess_reg;
    logic [CNT_W-1:0]  norm_reg;
    logic [25:0]       prod1_reg;
    logic [24:0]       prod2_reg;
    logic [16+SUM_W-1:0] prod3_reg;
    logic [DIVD_W-1:0] q_reg;
    logic [DIVS_W-1:0] rem_reg, dvs_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [DIVD_W-1:0] t1_reg, t2_reg, t3_reg;
    logic              done_reg;
    out_t              result_reg;

    logic [ADDR_W-1:0] addr_a, addr_b;
    logic [CNT_W-1:0]  top_a_idx, top_b_idx, n1, n2, nmax;
    logic [INN_W-1:0]  i1, i2;
    logic [WT_W-1:0]   w1, w2;
    logic [WT_W:0]     wdiff;
    logic [DIVS_W:0]   r_try;
    logic [DIVD_W+1:0] total;
    logic              top_a_lt;

    always_comb
    begin
        top_a_idx = count_a_reg - CNT_W'(1);
        top_b_idx = count_b_reg - CNT_W'(1);
        if (dp_cmd.top_rd)
        begin
            addr_a = top_a_idx[ADDR_W-1:0];
            addr_b = top_b_idx[ADDR_W-1:0];
        end
        else if (swap_reg)
        begin
            addr_a = p2_reg[ADDR_W-1:0];
            addr_b = p1_reg[ADDR_W-1:0];
        end
        else
        begin
            addr_a = p1_reg[ADDR_W-1:0];
            addr_b = p2_reg[ADDR_W-1:0];
        end
        n1 = swap_reg ? count_b_reg : count_a_reg;
        n2 = swap_reg ? count_a_reg : count_b_reg;
        i1 = swap_reg ? rd_inn_b_reg : rd_inn_a_reg;
        i2 = swap_reg ? rd_inn_a_reg : rd_inn_b_reg;
        w1 = swap_reg ? rd_wt_b_reg : rd_wt_a_reg;
        w2 = swap_reg ? rd_wt_a_reg : rd_wt_b_reg;
        wdiff = {w1[WT_W-1], w1} - {w2[WT_W-1], w2};
        if (wdiff[WT_W])
            wdiff = -wdiff;
        nmax = (count_a_reg > count_b_reg) ? count_a_reg : count_b_reg;
        top_a_lt = (count_b_reg != '0) &&
                   (((count_a_reg == '0) ? INN_W'(0) : rd_inn_a_reg) < rd_inn_b_reg);
        r_try = {rem_reg, q_reg[DIVD_W-1]};
        total = (DIVD_W+2)'(t1_reg) + (DIVD_W+2)'(t2_reg) + (DIVD_W+2)'(t3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_a && !count_a_reg[CNT_W-1])
        begin
            inn_a_mem[count_a_reg[ADDR_W-1:0]] <= item.innovation;
            wt_a_mem[count_a_reg[ADDR_W-1:0]]  <= item.gene_weight;
        end
        if (dp_cmd.load_b && !count_b_reg[CNT_W-1])
        begin
            inn_b_mem[count_b_reg[ADDR_W-1:0]] <= item.innovation;
            wt_b_mem[count_b_reg[ADDR_W-1:0]]  <= item.gene_weight;
        end
        rd_inn_a_reg <= inn_a_mem[addr_a];
        rd_wt_a_reg  <= wt_a_mem[addr_a];
        rd_inn_b_reg <= inn_b_mem[addr_b];
        rd_wt_b_reg  <= wt_b_mem[addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg      <= 16'd256;
            c2_reg      <= 16'd256;
            c3_reg      <= 16'd102;
            limit_reg   <= 10'd20;
            count_a_reg <= '0;
            count_b_reg <= '0;
            ovf_reg     <= 1'b0;
            swap_reg    <= 1'b0;
            p1_reg      <= '0;
            p2_reg      <= '0;
            dcnt_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= dp_cmd.finish;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_COEF_DISJOINT: c1_reg <= cfg_data;
                    REG_COEF_EXCESS:   c2_reg <= cfg_data;
                    REG_COEF_WEIGHT:   c3_reg <= cfg_data;
                    REG_SMALL_LIMIT:   limit_reg <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (dp_cmd.load_a)
            begin
                if (count_a_reg[CNT_W-1])
                    ovf_reg <= 1'b1;
                else
                    count_a_reg <= count_a_reg + CNT_W'(1);
            end
            if (dp_cmd.load_b)
            begin
                if (count_b_reg[CNT_W-1])
                    ovf_reg <= 1'b1;
                else
                    count_b_reg <= count_b_reg + CNT_W'(1);
            end
            if (dp_cmd.top_cmp)
            begin
                swap_reg <= top_a_lt;
                p1_reg   <= '0;
                p2_reg   <= '0;
            end
            if (dp_cmd.walk_cmp)
            begin
                if (i1 == i2)
                begin
                    p1_reg <= p1_reg + CNT_W'(1);
                    p2_reg <= p2_reg + CNT_W'(1);
                end
                else if (i1 > i2)
                    p2_reg <= p2_reg + CNT_W'(1);
                else
                    p1_reg <= p1_reg + CNT_W'(1);
            end
            if (dp_cmd.div_start)
                dcnt_reg <= DCNT_W'(DIVD_W);
            else if (dp_cmd.div_step)
                dcnt_reg <= dcnt_reg - DCNT_W'(1);
            if (dp_cmd.finish)
            begin
                count_a_reg <= '0;
                count_b_reg <= '0;
                ovf_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.top_cmp)
        begin
            match_reg <= '0;
            disj_reg  <= '0;
            sum_reg   <= '0;
        end
        if (dp_cmd.walk_cmp)
        begin
            if (i1 == i2)
            begin
                match_reg <= match_reg + 9'd1;
                sum_reg   <= sum_reg + SUM_W'(wdiff);
            end
            else
                disj_reg <= disj_reg + 10'd1;
        end
        if (dp_cmd.mul)
        begin
            excess_reg <= 9'(n1 - p1_reg);
            prod1_reg  <= c1_reg * disj_reg;
            prod2_reg  <= c2_reg * 9'(n1 - p1_reg);
            prod3_reg  <= c3_reg * sum_reg;
            if ({1'b0, nmax} < limit_reg || nmax == '0)
                norm_reg <= CNT_W'(1);
            else
                norm_reg <= nmax;
        end
        if (dp_cmd.div_start)
        begin
            rem_reg <= '0;
            case (dp_cmd.term_sel)
                TERM_DISJOINT:
                begin
                    q_reg   <= DIVD_W'({prod1_reg, 8'd0});
                    dvs_reg <= norm_reg;
                end
                TERM_EXCESS:
                begin
                    q_reg   <= DIVD_W'({prod2_reg, 8'd0});
                    dvs_reg <= norm_reg;
                end
                default:
                begin
                    q_reg   <= prod3_reg[16+SUM_W-1:8];
                    dvs_reg <= (match_reg == '0) ? DIVS_W'(1) : match_reg;
                end
            endcase
        end
        else if (dp_cmd.div_step)
        begin
            if (r_try >= {1'b0, dvs_reg})
            begin
                rem_reg <= DIVS_W'(r_try - {1'b0, dvs_reg});
                q_reg   <= {q_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= r_try[DIVS_W-1:0];
                q_reg   <= {q_reg[DIVD_W-2:0], 1'b0};
            end
        end
        if (dp_cmd.div_store)
        begin
            case (dp_cmd.term_sel)
                TERM_DISJOINT: t1_reg <= q_reg;
                TERM_EXCESS:   t2_reg <= q_reg;
                default:       t3_reg <= q_reg;
            endcase
        end
        if (dp_cmd.finish)
        begin
            result_reg.distance_value <= (total[DIVD_W+1:32] != '0) ? 32'hFFFF_FFFF
                                                                     : total[31:0];
            result_reg.matching_count <= match_reg;
            result_reg.disjoint_count <= disj_reg;
            result_reg.excess_count   <= excess_reg;
            result_reg.overflow_flag  <= ovf_reg;
        end
    end

    assign status.walk_done = (p1_reg >= n1) || (p2_reg >= n2);
    assign status.div_done  = (dcnt_reg == '0);
    assign done   = done_reg;
    assign result = result_reg;

    a_count_a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_a_reg <= CNT_W'(MAX_GENES))
        else $error("Store A count beyond capacity.");

    a_clear_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.finish |=> (count_a_reg == '0) && (count_b_reg == '0) && !ovf_reg)
        else $error("Stores not cleared after a compute.");

    a_done_follows_finish: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.finish |=> done_reg)
        else $error("Result strobe missing after a compute.");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.walk_cmp |-> (p1_reg < n1) && (p2_reg < n2))
        else $error("Merge step taken past the end of a genome.");

endmodule
